/* hdl/lz_token_stream_decompressor_core_defines.svh */
// Assertion macros shared by the checker of the LZ token stream decompressor.
// No dependencies; included by the checker file only.
`ifndef LZ_TOKEN_STREAM_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZ_TOKEN_STREAM_DECOMPRESSOR_CORE_DEFINES_SVH

// same-cycle implication under reset
`define LZTD_AP_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication under reset
`define LZTD_AP_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

/* hdl/lztd_pkg.sv */
// Package of the LZ token stream decompressor: token and status codes, widths,
// parameter defaults, controller state and interface types. No dependencies.
package lztd_pkg;

	// token codes
	localparam logic [7:0] CODE_ESCAPE = 8'h80;
	localparam logic [7:0] CODE_SHORT  = 8'h81;
	localparam logic [7:0] CODE_MEDIUM = 8'h92;
	localparam logic [7:0] CODE_LONG   = 8'hB3;

	// match status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNC     = 2'd1;
	localparam logic [1:0] ST_OFF_PROD  = 2'd2;
	localparam logic [1:0] ST_OFF_RANGE = 2'd3;

	// widths: copy length (16-bit field + 3), offset arithmetic (24-bit field + 1)
	localparam int LEN_W = 17;
	localparam int OFF_W = 26;
	localparam int OPS_W = 40;
	localparam int CNT_W = 4;
	localparam int WORD_W = 64;

	// parameter defaults
	localparam int DEF_WINDOW_BYTES = 65536;
	localparam int DEF_MAX_LENGTH   = 273;
	localparam int DEF_LANES        = 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_WR,
		S_PUSH,
		S_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd;
		logic wr;
		logic push_mid;
		logic push_final;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic copy_start;
		logic flush_start;
		logic lanes_full;
		logic rem_one;
		logic out_free;
		logic has_data;
		logic last;
	} sts_t;

endpackage

/* hdl/lztd_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
module lztd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hdl/lztd_dp.sv */
// Datapath: token parser, match checks, history window, word packer and
// output register. Depends on lztd_pkg and lztd_ram.
module lztd_dp #(
	parameter int WINDOW_BYTES = lztd_pkg::DEF_WINDOW_BYTES,
	parameter int MAX_LENGTH   = lztd_pkg::DEF_MAX_LENGTH,
	parameter int LANES        = lztd_pkg::DEF_LANES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lztd_pkg::cmd_t           cmd,
	output lztd_pkg::sts_t           sts,
	input  logic [7:0]               in_byte,
	input  logic                     in_last,
	output logic                     m_valid,
	input  logic                     m_ready,
	output logic [lztd_pkg::WORD_W-1:0] m_word,
	output logic [lztd_pkg::CNT_W-1:0]  m_count,
	output logic                     m_run_last,
	output logic                     m_end,
	output logic [1:0]               m_status
);
	import lztd_pkg::*;

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int PW = $clog2(WINDOW_BYTES + 1);
	localparam logic [OFF_W-1:0] WIN = OFF_W'(WINDOW_BYTES);
	localparam logic [OFF_W-1:0] MAXL = OFF_W'(MAX_LENGTH);

	// parser and stream state
	logic [7:0]       code_q;
	logic [OPS_W-1:0] ops_q;
	logic [2:0]       seen_q;
	logic [1:0]       halt_q;
	logic [AW-1:0]    wp_q;
	logic [PW-1:0]    prod_q;
	logic             last_q;
	// copy state
	logic [LEN_W-1:0] rem_q;
	logic [AW-1:0]    src_q;
	// word packer
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  lanes_q;
	// output register
	logic              m_valid_q;
	logic [WORD_W-1:0] m_word_q;
	logic [CNT_W-1:0]  m_count_q;
	logic              m_run_last_q;
	logic              m_end_q;
	logic [1:0]        m_status_q;

	logic [OPS_W-1:0] ops_n;
	logic [2:0]       seen_n;
	logic [2:0]       needed;
	logic             is_tok, complete, lit, copy_ok;
	logic [7:0]       lit_byte;
	logic [OFF_W-1:0] len_c, off_c, wp_e, src_c;
	logic [1:0]       bad_c;
	logic [7:0]       code_after;
	logic [1:0]       halt_n;
	logic             emit;
	logic [7:0]       emit_byte;
	logic [7:0]       rdata;
	logic             push;
	logic             out_free;

	// operand accumulate and token decode
	always_comb begin
		ops_n    = {ops_q[OPS_W-9:0], in_byte};
		seen_n   = seen_q + 3'd1;
		is_tok   = (in_byte >= CODE_ESCAPE) && (in_byte <= CODE_LONG);
		needed   = (code_q < CODE_MEDIUM) ? 3'd1 : (code_q < CODE_LONG) ? 3'd2 : 3'd5;
		complete = (code_q != 8'd0) && (seen_n >= needed);
		wp_e     = OFF_W'(wp_q);
		if (code_q < CODE_MEDIUM) begin
			len_c = OFF_W'(code_q - CODE_SHORT) + OFF_W'(3);
			off_c = OFF_W'(ops_n[7:0]) + OFF_W'(1);
		end else if (code_q < CODE_LONG) begin
			len_c = OFF_W'(code_q - CODE_MEDIUM) + OFF_W'(3);
			off_c = OFF_W'(ops_n[15:0]) + OFF_W'(1);
		end else begin
			len_c = OFF_W'({ops_n[31:24], ops_n[39:32]}) + OFF_W'(3);
			off_c = OFF_W'({ops_n[7:0], ops_n[15:8], ops_n[23:16]}) + OFF_W'(1);
		end
		if (off_c > WIN || len_c > MAXL) begin
			bad_c = ST_OFF_RANGE;
		end else if (off_c > OFF_W'(prod_q)) begin
			bad_c = ST_OFF_PROD;
		end else begin
			bad_c = ST_OK;
		end
		src_c = (wp_e >= off_c) ? wp_e - off_c : wp_e + WIN - off_c;
		lit      = 1'b0;
		copy_ok  = 1'b0;
		lit_byte = in_byte;
		code_after = code_q;
		if (halt_q == ST_OK) begin
			if (code_q == 8'd0) begin
				lit = !is_tok;
				code_after = is_tok ? in_byte : 8'd0;
			end else if (complete) begin
				code_after = 8'd0;
				lit_byte   = ops_n[7:0];
				lit        = (code_q == CODE_ESCAPE);
				copy_ok    = (code_q != CODE_ESCAPE) && (bad_c == ST_OK);
			end
		end
		if (halt_q != ST_OK) begin
			halt_n = halt_q;
		end else if (complete && code_q != CODE_ESCAPE && bad_c != ST_OK) begin
			halt_n = bad_c;
		end else if (in_last && code_after != 8'd0) begin
			halt_n = ST_TRUNC;
		end else begin
			halt_n = ST_OK;
		end
	end

	assign out_free  = !m_valid_q || m_ready;
	assign emit      = (cmd.accept && lit) || cmd.wr;
	assign emit_byte = cmd.wr ? rdata : lit_byte;
	assign push      = cmd.push_mid || cmd.push_final;

	// status to controller
	always_comb begin
		sts.copy_start  = copy_ok;
		sts.flush_start = !copy_ok && (lit || in_last);
		sts.lanes_full  = (lanes_q + CNT_W'(1)) >= CNT_W'(LANES);
		sts.rem_one     = (rem_q == LEN_W'(1));
		sts.out_free    = out_free;
		sts.has_data    = (lanes_q != '0);
		sts.last        = last_q;
	end

	lztd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk   (clk),
		.we    (emit),
		.waddr (wp_q),
		.wdata (emit_byte),
		.re    (cmd.rd),
		.raddr (src_q),
		.rdata (rdata)
	);

	// parser, pointers and copy state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			ops_q  <= '0;
			seen_q <= '0;
			halt_q <= ST_OK;
			wp_q   <= '0;
			prod_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				last_q <= in_last;
				halt_q <= halt_n;
				if (halt_q == ST_OK) begin
					if (code_q == 8'd0) begin
						code_q <= code_after;
						ops_q  <= '0;
						seen_q <= '0;
					end else if (complete) begin
						code_q <= '0;
						ops_q  <= '0;
						seen_q <= '0;
					end else begin
						ops_q  <= ops_n;
						seen_q <= seen_n;
					end
				end
			end
			if (emit) begin
				wp_q <= (OFF_W'(wp_q) + OFF_W'(1) >= WIN) ? '0 : wp_q + AW'(1);
				if (OFF_W'(prod_q) < WIN) begin
					prod_q <= prod_q + PW'(1);
				end
			end
			// end of stream: start afresh
			if (cmd.push_final && last_q) begin
				code_q <= '0;
				ops_q  <= '0;
				seen_q <= '0;
				halt_q <= ST_OK;
				wp_q   <= '0;
				prod_q <= '0;
			end
		end
	end

	// copy source and remaining length
	always_ff @(posedge clk) begin
		if (cmd.accept && copy_ok) begin
			rem_q <= LEN_W'(len_c);
			src_q <= AW'(src_c);
		end else if (cmd.wr) begin
			rem_q <= rem_q - LEN_W'(1);
			src_q <= (OFF_W'(src_q) + OFF_W'(1) >= WIN) ? '0 : src_q + AW'(1);
		end
	end

	// word packer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= '0;
			lanes_q <= '0;
		end else if (push) begin
			word_q  <= '0;
			lanes_q <= '0;
		end else if (emit) begin
			for (int i = 0; i < LANES; i++) begin
				if (lanes_q == CNT_W'(i)) begin
					word_q[8*i +: 8] <= emit_byte;
				end
			end
			lanes_q <= lanes_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (push) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_word_q     <= word_q;
			m_count_q    <= lanes_q;
			m_run_last_q <= cmd.push_final;
			m_end_q      <= cmd.push_final && last_q;
			m_status_q   <= (cmd.push_final && last_q) ? halt_q : ST_OK;
		end
	end

	assign m_valid    = m_valid_q;
	assign m_word     = m_word_q;
	assign m_count    = m_count_q;
	assign m_run_last = m_run_last_q;
	assign m_end      = m_end_q;
	assign m_status   = m_status_q;
endmodule

/* hdl/lztd_ctrl.sv */
// Controller state machine: input acceptance, copy sequencing, result pushes.
// Depends on lztd_pkg.
module lztd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lztd_pkg::sts_t sts,
	output lztd_pkg::cmd_t cmd
);
	import lztd_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.copy_start) begin
						state_n = S_RD;
					end else if (sts.flush_start) begin
						state_n = S_FLUSH;
					end
				end
			end
			S_RD: state_n = S_WR;
			S_WR: begin
				if (sts.rem_one) begin
					state_n = S_FLUSH;
				end else if (sts.lanes_full) begin
					state_n = S_PUSH;
				end else begin
					state_n = S_RD;
				end
			end
			S_PUSH: begin
				if (sts.out_free) begin
					state_n = S_RD;
				end
			end
			S_FLUSH: begin
				if (sts.out_free || !(sts.has_data || sts.last)) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_RD:   cmd.rd = 1'b1;
			S_WR:   cmd.wr = 1'b1;
			S_PUSH: cmd.push_mid = sts.out_free;
			S_FLUSH: cmd.push_final = sts.out_free && (sts.has_data || sts.last);
			default: cmd = '0;
		endcase
	end
endmodule

/* hdl/lz_token_stream_decompressor_core.sv */
// Top level of the LZ token stream decompressor: controller plus datapath.
// Depends on lztd_pkg, lztd_ctrl, lztd_dp.
//
// Usage:
//   s_axis carries one compressed byte per transaction (tdata = in_byte,
//   tlast = stream_last). m_axis carries decoded words of up to LANES bytes;
//   tlast marks the last result of one input byte, tuser holds stream_end
//   and status. A status-only result (byte_count 0) closes a stream whose
//   last byte decodes nothing.
// Sequence:
//   Prefix and operand bytes, and a rejected match, are only accepted, with no
//   push unless they end the stream. A literal or escape is accepted, then its
//   result is pushed. A match is accepted, then each copied byte is one history
//   read and then one write, and each full word before the final word is pushed.
// Reset: arst_n clears the parser, pointers, word packer and output valid;
//   history contents are not cleared and are never read before written.
// Stall: a result waits in the output register; while m_axis_tready is low
//   the copy sequence stops at the next push, and s_axis_tready drops as
//   soon as the next result is due.
module lz_token_stream_decompressor_core #(
	parameter int WINDOW_BYTES = lztd_pkg::DEF_WINDOW_BYTES,
	parameter int MAX_LENGTH   = lztd_pkg::DEF_MAX_LENGTH,
	parameter int LANES        = lztd_pkg::DEF_LANES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] out_bytes, [67:64] byte_count, zero pad
	output logic        m_axis_tlast,
	output logic [2:0]  m_axis_tuser    // [0] stream_end, [2:1] status
);
	import lztd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [WORD_W-1:0] word;
	logic [CNT_W-1:0]  count;
	logic              end_flag;
	logic [1:0]        status;

	lztd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lztd_dp #(
		.WINDOW_BYTES (WINDOW_BYTES),
		.MAX_LENGTH   (MAX_LENGTH),
		.LANES        (LANES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_word     (word),
		.m_count    (count),
		.m_run_last (m_axis_tlast),
		.m_end      (end_flag),
		.m_status   (status)
	);

	assign m_axis_tdata = {4'd0, count, word};
	assign m_axis_tuser = {status, end_flag};
endmodule

/* hdl/lztd_chk.sv */
// Port-level checker for the LZ token stream decompressor, with its bind.
// Depends on lz_token_stream_decompressor_core_defines.svh.
`include "lz_token_stream_decompressor_core_defines.svh"

module lztd_chk #(
	parameter int LANES = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [2:0]  m_axis_tuser
);
	// stalled result keeps valid and tdata
	`LZTD_AP_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
	// never more bytes than lanes
	`LZTD_AP_NOW(a_count, m_axis_tvalid, m_axis_tdata[67:64] <= 4'(LANES), "byte count above lane count")
	// nonzero status only on the stream's final result
	`LZTD_AP_NOW(a_status, m_axis_tvalid && m_axis_tuser[2:1] != 2'd0, m_axis_tuser[0], "status without stream end")
	// stream end is always the last result of its input
	`LZTD_AP_NOW(a_end, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "stream end without tlast")
endmodule

bind lz_token_stream_decompressor_core lztd_chk #(.LANES(LANES)) u_lztd_chk (.*);

/* sim/lz_token_stream_decompressor_core_tb.sv */
// Testbench for lz_token_stream_decompressor_core: streams LZ tokens, predicts decoded words.
// Depends on lztd_pkg and the core RTL; scoreboard class holds the expected results.
module lz_token_stream_decompressor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lztd_pkg::*;

	localparam int WIN = DEF_WINDOW_BYTES;
	localparam int MAXLEN = DEF_MAX_LENGTH;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        rlast;
		logic        send;
		logic [1:0]  st;
	} word_t;

	int errors = 0;

	task automatic report(string what, word_t got, word_t exp);
		errors++;
		$display("mismatch %s: got %h/%0d/%b/%b/%0d exp %h/%0d/%b/%b/%0d", what,
			got.data, got.cnt, got.rlast, got.send, got.st,
			exp.data, exp.cnt, exp.rlast, exp.send, exp.st);
	endtask

	// decoder model plus queue of expected output words
	class lz_scoreboard;
		logic [7:0] hist [WIN];
		int wp, produced, ops_seen;
		logic [7:0] code;
		logic [39:0] ops;
		logic [1:0] halt;
		word_t pending [$];
		word_t cur;
		int matched;

		function void clear();
			wp = 0; produced = 0; code = 0; ops = 0; ops_seen = 0; halt = ST_OK;
		endfunction

		function void put(logic [7:0] b);
			hist[wp] = b;
			wp = (wp + 1 >= WIN) ? 0 : wp + 1;
			if (produced < WIN) produced++;
			cur.data[8*cur.cnt +: 8] = b;
			cur.cnt++;
			if (cur.cnt == 8) begin
				pending = {pending, cur};
				cur = '0;
			end
		endfunction

		function void copy(int len, int off);
			int src;
			if (off > WIN || len > MAXLEN) begin
				halt = ST_OFF_RANGE;
				return;
			end
			if (off > produced) begin
				halt = ST_OFF_PROD;
				return;
			end
			src = (wp >= off) ? wp - off : wp + WIN - off;
			for (int k = 0; k < len; k++) begin
				put(hist[src]);
				src = (src + 1 >= WIN) ? 0 : src + 1;
			end
		endfunction

		function void note_input(logic [7:0] b, logic last);
			int base, need, n;
			logic [7:0] c;
			base = pending.size();
			cur = '0;
			if (halt == ST_OK) begin
				if (code == 0) begin
					if (b >= CODE_ESCAPE && b <= CODE_LONG) begin
						code = b; ops = 0; ops_seen = 0;
					end else put(b);
				end else begin
					ops = {ops[31:0], b};
					ops_seen++;
					need = (code < CODE_MEDIUM) ? 1 : (code < CODE_LONG) ? 2 : 5;
					if (ops_seen >= need) begin
						c = code;
						code = 0; ops_seen = 0;
						if (c == CODE_ESCAPE) put(ops[7:0]);
						else if (c < CODE_MEDIUM) copy(c - CODE_SHORT + 3, ops[7:0] + 1);
						else if (c < CODE_LONG) copy(c - CODE_MEDIUM + 3, ops[15:0] + 1);
						else copy({ops[31:24], ops[39:32]} + 3,
							{ops[7:0], ops[15:8], ops[23:16]} + 1);
						ops = 0;
					end
				end
				if (cur.cnt != 0) pending = {pending, cur};
				if (last && code != 0 && halt == ST_OK) halt = ST_TRUNC;
			end
			n = pending.size() - base;
			if (last) begin
				if (n == 0) begin
					cur = '0;
					pending = {pending, cur};
					n = 1;
				end
				pending[pending.size()-1].send = 1'b1;
				pending[pending.size()-1].st = halt;
				clear();
			end
			if (n > 0) pending[pending.size()-1].rlast = 1'b1;
		endfunction

		task check_result(word_t got);
			word_t exp;
			if (pending.size() == 0) begin
				report("unexpected", got, '0);
				return;
			end
			exp = pending.pop_front();
			matched++;
			if (got.data !== exp.data) report("out_bytes", got, exp);
			if (got.cnt !== exp.cnt) report("byte_count", got, exp);
			if (got.rlast !== exp.rlast) report("run_last", got, exp);
			if (got.send !== exp.send) report("stream_end", got, exp);
			if (got.st !== exp.st) report("status", got, exp);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tlast = 0, m_axis_tready = 0;
	logic [7:0] s_axis_tdata = 0;
	logic s_axis_tready, m_axis_tvalid, m_axis_tlast;
	logic [71:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	lz_token_stream_decompressor_core DUT (.*);

	lz_scoreboard sb = new();
	int idle_pct = 26;
	int hold_off = 0;
	int n_items = 0;
	logic [7:0] tok [$];

	initial forever #10 clk = ~clk;

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

	// result side: random stall, plus a long counted hold-off on request
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result({m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast,
				m_axis_tuser[0], m_axis_tuser[2:1]});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	// one input transaction, with random gaps
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(b, last);
		n_items++;
	endtask

	task automatic send_stream(logic last_flag);
		for (int i = 0; i < tok.size(); i++)
			send_byte(tok[i], last_flag && i == tok.size() - 1);
		tok.delete();
	endtask

	// add one byte at the end of tok
	task automatic append(int v);
		tok = {tok, 8'(v)};
	endtask

	// a random well-formed token appended to tok
	task automatic add_token(int produced);
		int kind, off;
		kind = $urandom_range(9);
		off = (produced > 0) ? $urandom_range(produced - 1) : 0;
		if (produced == 0 || kind < 4) begin
			append($urandom_range(1) ? $urandom_range(8'h7F) : $urandom_range(8'hFF, 8'hB4));
		end else if (kind == 4) begin
			append(int'(CODE_ESCAPE));
			append($urandom_range(255));
		end else if (kind < 7) begin
			if (off > 255) off = $urandom_range(255);
			append($urandom_range(8'h91, 8'h81));
			append(off);
		end else if (kind < 9) begin
			append($urandom_range(8'hB2, 8'h92));
			append(off >> 8);
			append(off);
		end else begin
			int len;
			len = $urandom_range(40);
			append(int'(CODE_LONG));
			append(len);
			append(len >> 8);
			append(off);
			append(off >> 8);
			append(off >> 16);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		sb.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: literals at the edges, escape, overlapping short copy
		tok = '{8'h00, 8'h7F, 8'hB4, 8'hFF, CODE_ESCAPE, 8'h80, CODE_ESCAPE, 8'hB3,
			CODE_SHORT, 8'h00, 8'h91, 8'h04};
		send_stream(1'b1);
		// medium and long matches with max offset inside produced data
		tok = '{8'h41, 8'h42, 8'h43, 8'hB2, 8'h00, 8'h02, CODE_LONG, 8'h0E, 8'h01,
			8'h00, 8'h00, 8'h00};
		send_stream(1'b1);
		// offset beyond output, then ignored bytes
		tok = '{8'h11, CODE_SHORT, 8'h05, 8'h22};
		send_stream(1'b1);
		// offset beyond window and length beyond limit
		tok = '{8'h11, CODE_LONG, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h33};
		send_stream(1'b1);
		tok = '{8'h11, CODE_LONG, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
		send_stream(1'b1);
		// truncated token, and a lone prefix as the whole stream
		tok = '{8'h55, CODE_MEDIUM, 8'h00};
		send_stream(1'b1);
		tok = '{CODE_LONG};
		send_stream(1'b1);
		drain();

		// stall output for a long stretch while a long copy fills the block
		hold_off = 300;
		tok = '{8'h01, 8'h02, CODE_LONG, 8'hF0, 8'h00, 8'h01, 8'h00, 8'h00, 8'h03};
		send_stream(1'b1);
		drain();

		// random streams; a quiet stretch with no idling in the middle
		for (int s = 0; n_items < 350; s++) begin
			int prod, pre;
			idle_pct = (s >= 6 && s < 10) ? 0 : 26;
			prod = 0;
			repeat ($urandom_range(12, 2)) begin
				pre = tok.size();
				add_token(prod);
				prod += tok.size() - pre + 10;
			end
			// noise: random byte somewhere, sometimes cut short
			if ($urandom_range(4) == 0) tok[$urandom_range(tok.size()-1)] = 8'($urandom_range(255));
			if ($urandom_range(5) == 0) append($urandom_range(8'hB3, 8'h80));
			send_stream(1'b1);
		end
		idle_pct = 26;
		drain();

		$display("ran %0d input bytes, %0d results checked: literals, escapes, all match kinds,",
			n_items, sb.matched);
		$display("overlaps, truncation and bad-offset halts, long output stall");
		if (errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/lztd_pkg.sv
hdl/lztd_ram.sv
hdl/lztd_dp.sv
hdl/lztd_ctrl.sv
hdl/lz_token_stream_decompressor_core.sv
hdl/lztd_chk.sv
sim/lz_token_stream_decompressor_core_tb.sv
